@@ hw/rtl/w2s_pkg.sv @@
package w2s_pkg;

    // register indexes on the configuration port
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_CAMERA_X     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAMERA_Y     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CAMERA_Z     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CAMERA_PITCH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CAMERA_YAW   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CAMERA_ROLL  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FIELD_OF_VIEW = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_SIZE  = 3'd7;

    localparam logic [13:0] FOV_RESET    = 14'd5760;
    localparam logic [31:0] SCREEN_RESET = 32'd70780800;
    localparam logic [13:0] FOV_MIN      = 14'd64;
    localparam logic [13:0] FOV_MAX      = 14'd11456;

    // angle units are 1/128 degree
    localparam logic signed [17:0] TURN_UNITS    = 18'sd46080;
    localparam logic signed [17:0] TWO_TURNS     = 18'sd92160;
    localparam logic [15:0] QUARTER_1 = 16'd11520;
    localparam logic [15:0] QUARTER_2 = 16'd23040;
    localparam logic [15:0] QUARTER_3 = 16'd34560;

    localparam int CORDIC_STEPS = 24;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

    // one angle unit is pi/23040 in q30: whole steps, leftover numerator and rounding
    localparam logic [17:0] Z_STEP  = 18'd146408;
    localparam logic [14:0] Z_FRAC  = 15'd19106;
    localparam logic [13:0] Z_RND   = 14'd11520;
    // ceil(2^25 / 45), exact for the 19-bit leftover after the shift by 9
    localparam logic [19:0] Z_RECIP = 20'd745655;

    // point datapath widths
    localparam int DIFF_W = 33;
    localparam int BAS_W  = 18;
    localparam int PROD_W = 51;
    localparam int DOT_W  = 53;
    localparam int T_W    = 37;
    localparam int PP_W   = 53;
    localparam int NUM_W  = 69;
    localparam int QUO_W  = 24;

    typedef enum logic [3:0] {
        RB_IDLE,
        RB_PREP,
        RB_ZMUL,
        RB_CLOAD,
        RB_CORDIC,
        RB_SAVE,
        RB_FMUL,
        RB_FDIV,
        RB_FSAVE,
        RB_BAS_A,
        RB_BAS_B,
        RB_BAS_C
    } rb_state_t;

    function automatic logic [31:0] atan_q30(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0:  v = 32'h3243F6A8;
            5'd1:  v = 32'h1DAC6705;
            5'd2:  v = 32'h0FADBAFC;
            5'd3:  v = 32'h07F56EA6;
            5'd4:  v = 32'h03FEAB76;
            5'd5:  v = 32'h01FFD55B;
            5'd6:  v = 32'h00FFFAAA;
            5'd7:  v = 32'h007FFF55;
            5'd8:  v = 32'h003FFFEA;
            5'd9:  v = 32'h001FFFFD;
            5'd10: v = 32'h000FFFFF;
            5'd11: v = 32'h0007FFFF;
            5'd12: v = 32'h0003FFFF;
            5'd13: v = 32'h0001FFFF;
            5'd14: v = 32'h0000FFFF;
            5'd15: v = 32'h00007FFF;
            5'd16: v = 32'h00003FFF;
            5'd17: v = 32'h00001FFF;
            5'd18: v = 32'h00000FFF;
            5'd19: v = 32'h000007FF;
            5'd20: v = 32'h000003FF;
            5'd21: v = 32'h000001FF;
            5'd22: v = 32'h000000FF;
            5'd23: v = 32'h0000007F;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

    // q30 to q16, round half up
    function automatic logic signed [18:0] to_q16(input logic signed [33:0] v);
        logic signed [33:0] t;
        t = v + 34'sd8192;
        return t[32:14];
    endfunction

    // q16 product rounded half up
    function automatic logic signed [21:0] mul16(input logic signed [21:0] a,
                                                 input logic signed [21:0] b);
        logic signed [43:0] p;
        p = a * b;
        p = p + 44'sd32768;
        return p[37:16];
    endfunction

    function automatic logic signed [17:0] clamp18(input logic signed [22:0] v);
        logic signed [17:0] r;
        if (v > 23'sd131071)
            r = 18'sh1FFFF;
        else if (v < -23'sd131072)
            r = 18'sh20000;
        else
            r = v[17:0];
        return r;
    endfunction

    // q8 pixel to rounded, saturated pixel
    function automatic logic [15:0] to_pixel(input logic signed [26:0] p8);
        logic signed [26:0] t;
        logic signed [18:0] p;
        logic [15:0] r;
        t = p8 + 27'sd128;
        p = t[26:8];
        if (p > 19'sd32767)
            r = 16'h7FFF;
        else if (p < -19'sd32768)
            r = 16'h8000;
        else
            r = p[15:0];
        return r;
    endfunction

endpackage

@@ hw/rtl/world_to_screen_projection.sv @@
// Perspective projection of world points (signed Q24.8) to screen pixels. A point is taken
// on every cycle that s_tready is high, and its pixel pair leaves on m_tdata through these stages:
// one stage for the camera offset, one for the nine basis products, one for the dot sums,
// one for rounding and the depth clamp, three for the focal product and its range check, 24
// for the two pipelined one-bit-per-stage dividers that scale by focal/depth, and one for
// the final rounding and 16-bit saturation. A stall on m_tready holds the whole pipeline.
// Every configuration write, and reset itself, starts a rebuild of the rotation basis and
// focal scale in a sequencer around one CORDIC rotator, a reciprocal multiply for the angle
// scaling and one radix-2 divider: four angles (reduce, scale, load, rotate, save), then the
// focal product, divide and save and the basis products and sums; s_tready stays low throughout.
module world_to_screen_projection
    import w2s_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [95:0]          s_tdata,   // point_x, point_y, point_z
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [31:0]          m_tdata,   // pixel_x, pixel_y
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);

    // ---------------- configuration registers ----------------
    logic signed [31:0] cam_x_reg, cam_y_reg, cam_z_reg;
    logic signed [15:0] pitch_reg, yaw_reg, roll_reg;
    logic [13:0]        fov_reg;
    logic [31:0]        screen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cam_x_reg  <= '0;
            cam_y_reg  <= '0;
            cam_z_reg  <= '0;
            pitch_reg  <= '0;
            yaw_reg    <= '0;
            roll_reg   <= '0;
            fov_reg    <= FOV_RESET;
            screen_reg <= SCREEN_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CAMERA_X:      cam_x_reg  <= cfg_data;
                REG_CAMERA_Y:      cam_y_reg  <= cfg_data;
                REG_CAMERA_Z:      cam_z_reg  <= cfg_data;
                REG_CAMERA_PITCH:  pitch_reg  <= cfg_data[15:0];
                REG_CAMERA_YAW:    yaw_reg    <= cfg_data[15:0];
                REG_CAMERA_ROLL:   roll_reg   <= cfg_data[15:0];
                REG_FIELD_OF_VIEW: fov_reg    <= cfg_data[13:0];
                REG_SCREEN_SIZE:   screen_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    // ---------------- rebuild sequencer ----------------
    rb_state_t   state_reg, state_next;
    logic [1:0]  ang_idx_reg;
    logic [5:0]  cnt_reg;
    logic        busy, div_step, cordic_step;

    logic [1:0]  quad_reg;
    logic [13:0] ang_rem_reg;
    logic [31:0] zbase_reg;
    logic [18:0] zfrac_reg;
    logic [63:0] div_num_reg;
    logic [31:0] div_rem_reg, div_den_reg;
    logic signed [33:0] cx_reg, cy_reg;
    logic signed [32:0] cz_reg;
    logic signed [21:0] sin_q16_reg [3];
    logic signed [21:0] cos_q16_reg [3];
    logic signed [33:0] fov_sin_reg, fov_cos_reg;
    logic signed [21:0] srsp_reg, crsp_reg;
    logic signed [21:0] bprod_reg [12];
    logic signed [BAS_W-1:0] basis_reg [9];
    logic [31:0] focal_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            RB_IDLE:   state_next = RB_IDLE;
            RB_PREP:   state_next = RB_ZMUL;
            RB_ZMUL:   state_next = RB_CLOAD;
            RB_CLOAD:  state_next = RB_CORDIC;
            RB_CORDIC: state_next = (cnt_reg == 6'(CORDIC_STEPS - 1)) ? RB_SAVE : RB_CORDIC;
            RB_SAVE:   state_next = (ang_idx_reg == 2'd3) ? RB_FMUL : RB_PREP;
            RB_FMUL:   state_next = RB_FDIV;
            RB_FDIV:   state_next = (cnt_reg == 6'd63) ? RB_FSAVE : RB_FDIV;
            RB_FSAVE:  state_next = RB_BAS_A;
            RB_BAS_A:  state_next = RB_BAS_B;
            RB_BAS_B:  state_next = RB_BAS_C;
            RB_BAS_C:  state_next = RB_IDLE;
            default:   state_next = RB_IDLE;
        endcase
        if (cfg_we)
            state_next = RB_PREP;
    end

    always_comb
    begin
        busy        = (state_reg != RB_IDLE);
        div_step    = (state_reg == RB_FDIV);
        cordic_step = (state_reg == RB_CORDIC);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= RB_PREP;
            ang_idx_reg <= '0;
            cnt_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_next != state_reg)
                cnt_reg <= '0;
            else
                cnt_reg <= cnt_reg + 6'd1;
            if (cfg_we)
                ang_idx_reg <= '0;
            else if (state_reg == RB_SAVE)
                ang_idx_reg <= ang_idx_reg + 2'd1;
        end
    end

    // angle reduction to one turn and split into quadrant and remainder
    logic [13:0]        fov_cl;
    logic signed [17:0] ang_a, ang_add1, ang_add2, ang_sub1, ang_u;
    logic [15:0]        ang_u16;
    logic [1:0]         ang_q;
    logic [15:0]        ang_r;

    always_comb
    begin
        if (fov_reg < FOV_MIN)
            fov_cl = FOV_MIN;
        else if (fov_reg > FOV_MAX)
            fov_cl = FOV_MAX;
        else
            fov_cl = fov_reg;
        case (ang_idx_reg)
            2'd0:    ang_a = {pitch_reg[15], pitch_reg, 1'b0};
            2'd1:    ang_a = {yaw_reg[15], yaw_reg, 1'b0};
            2'd2:    ang_a = {roll_reg[15], roll_reg, 1'b0};
            default: ang_a = {4'b0000, fov_cl};
        endcase
        ang_add1 = ang_a + TURN_UNITS;
        ang_add2 = ang_a + TWO_TURNS;
        ang_sub1 = ang_a - TURN_UNITS;
        if (ang_a < 0)
            ang_u = (ang_add1 < 0) ? ang_add2 : ang_add1;
        else if (ang_a >= TURN_UNITS)
            ang_u = ang_sub1;
        else
            ang_u = ang_a;
        ang_u16 = ang_u[15:0];
        if (ang_u16 >= QUARTER_3)
        begin
            ang_q = 2'd3;
            ang_r = ang_u16 - QUARTER_3;
        end
        else if (ang_u16 >= QUARTER_2)
        begin
            ang_q = 2'd2;
            ang_r = ang_u16 - QUARTER_2;
        end
        else if (ang_u16 >= QUARTER_1)
        begin
            ang_q = 2'd1;
            ang_r = ang_u16 - QUARTER_1;
        end
        else
        begin
            ang_q = 2'd0;
            ang_r = ang_u16;
        end
    end

    // remainder angle to q30 radians: whole steps plus the leftover divided by 23040
    logic [27:0] z_lin;
    logic [38:0] z_prod;

    always_comb
    begin
        z_lin  = 28'(ang_rem_reg) * 28'(Z_FRAC) + 28'(Z_RND);
        z_prod = 39'(zfrac_reg) * 39'(Z_RECIP);
    end

    // focal divider step, quotient shifts into the numerator register
    logic [31:0] div_sh;
    logic        div_ge;

    always_comb
    begin
        div_sh = {div_rem_reg[30:0], div_num_reg[63]};
        div_ge = (div_sh >= div_den_reg);
    end

    // cordic rotation step
    logic signed [33:0] cx_sh, cy_sh;
    logic signed [32:0] atan_s;

    always_comb
    begin
        cx_sh  = cx_reg >>> cnt_reg[4:0];
        cy_sh  = cy_reg >>> cnt_reg[4:0];
        atan_s = signed'({1'b0, atan_q30(cnt_reg[4:0])});
    end

    // quadrant fold of the cordic result
    logic signed [33:0] sn, cs;

    always_comb
    begin
        case (quad_reg)
            2'd0:
            begin
                sn = cy_reg;
                cs = cx_reg;
            end
            2'd1:
            begin
                sn = cx_reg;
                cs = -cy_reg;
            end
            2'd2:
            begin
                sn = -cy_reg;
                cs = -cx_reg;
            end
            default:
            begin
                sn = -cx_reg;
                cs = cy_reg;
            end
        endcase
    end

    // focal scale numerator: w * cos * 128 + sin / 2
    logic [30:0] fs_cl, fc_cl;
    logic [63:0] f_num;

    always_comb
    begin
        fs_cl = (fov_sin_reg < 34'sd1) ? 31'd1 : fov_sin_reg[30:0];
        fc_cl = (fov_cos_reg < 34'sd0) ? 31'd0 : fov_cos_reg[30:0];
        f_num = (64'(screen_reg[15:0]) * 64'(fc_cl) << 7) + 64'(fs_cl >> 1);
    end

    // basis sums
    logic signed [22:0] bsum [9];

    always_comb
    begin
        bsum[0] = 23'(bprod_reg[0]);
        bsum[1] = 23'(bprod_reg[1]);
        bsum[2] = 23'(sin_q16_reg[0]);
        bsum[3] = 23'(bprod_reg[2]) - 23'(bprod_reg[3]);
        bsum[4] = 23'(bprod_reg[4]) + 23'(bprod_reg[5]);
        bsum[5] = -23'(bprod_reg[6]);
        bsum[6] = -(23'(bprod_reg[7]) + 23'(bprod_reg[8]));
        bsum[7] = 23'(bprod_reg[9]) - 23'(bprod_reg[10]);
        bsum[8] = 23'(bprod_reg[11]);
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            RB_PREP:
            begin
                quad_reg    <= ang_q;
                ang_rem_reg <= ang_r[13:0];
            end
            RB_ZMUL:
            begin
                zbase_reg <= 32'(ang_rem_reg) * 32'(Z_STEP);
                zfrac_reg <= z_lin[27:9];
            end
            RB_CLOAD:
            begin
                cx_reg <= CORDIC_GAIN;
                cy_reg <= '0;
                cz_reg <= signed'({1'b0, zbase_reg + 32'(z_prod[38:25])});
            end
            RB_CORDIC:
            begin
                if (!cz_reg[32])
                begin
                    cx_reg <= cx_reg - cy_sh;
                    cy_reg <= cy_reg + cx_sh;
                    cz_reg <= cz_reg - atan_s;
                end
                else
                begin
                    cx_reg <= cx_reg + cy_sh;
                    cy_reg <= cy_reg - cx_sh;
                    cz_reg <= cz_reg + atan_s;
                end
            end
            RB_SAVE:
            begin
                if (ang_idx_reg == 2'd3)
                begin
                    fov_sin_reg <= sn;
                    fov_cos_reg <= cs;
                end
                else
                begin
                    sin_q16_reg[ang_idx_reg] <= 22'(to_q16(sn));
                    cos_q16_reg[ang_idx_reg] <= 22'(to_q16(cs));
                end
            end
            RB_FMUL:
            begin
                div_num_reg <= f_num;
                div_den_reg <= {1'b0, fs_cl};
                div_rem_reg <= '0;
            end
            RB_FSAVE:
                focal_reg <= (|div_num_reg[63:32]) ? 32'hFFFFFFFF : div_num_reg[31:0];
            RB_BAS_A:
            begin
                srsp_reg <= mul16(sin_q16_reg[2], sin_q16_reg[0]);
                crsp_reg <= mul16(cos_q16_reg[2], sin_q16_reg[0]);
            end
            RB_BAS_B:
            begin
                bprod_reg[0]  <= mul16(cos_q16_reg[0], cos_q16_reg[1]);
                bprod_reg[1]  <= mul16(cos_q16_reg[0], sin_q16_reg[1]);
                bprod_reg[2]  <= mul16(srsp_reg, cos_q16_reg[1]);
                bprod_reg[3]  <= mul16(cos_q16_reg[2], sin_q16_reg[1]);
                bprod_reg[4]  <= mul16(srsp_reg, sin_q16_reg[1]);
                bprod_reg[5]  <= mul16(cos_q16_reg[2], cos_q16_reg[1]);
                bprod_reg[6]  <= mul16(sin_q16_reg[2], cos_q16_reg[0]);
                bprod_reg[7]  <= mul16(crsp_reg, cos_q16_reg[1]);
                bprod_reg[8]  <= mul16(sin_q16_reg[2], sin_q16_reg[1]);
                bprod_reg[9]  <= mul16(cos_q16_reg[1], sin_q16_reg[2]);
                bprod_reg[10] <= mul16(crsp_reg, sin_q16_reg[1]);
                bprod_reg[11] <= mul16(cos_q16_reg[2], cos_q16_reg[0]);
            end
            RB_BAS_C:
            begin
                for (int i = 0; i < 9; i++)
                    basis_reg[i] <= clamp18(bsum[i]);
            end
            default:
            begin
                if (div_step)
                begin
                    div_rem_reg <= div_ge ? (div_sh - div_den_reg) : div_sh;
                    div_num_reg <= {div_num_reg[62:0], div_ge};
                end
            end
        endcase
    end

    // ---------------- point pipeline ----------------
    logic adv;
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv && !busy && !cordic_step;

    // stage 1: offset from camera
    logic                     v1_reg;
    logic signed [DIFF_W-1:0] d1_reg [3];

    // stage 2: basis products
    logic                     v2_reg;
    logic signed [PROD_W-1:0] p2_reg [9];

    // stage 3: dot sums, ordered forward, right, up
    logic                     v3_reg;
    logic signed [DOT_W-1:0]  dot3_reg [3];

    // stage 4: magnitudes and clamped depth
    logic                     v4_reg;
    logic [T_W-1:0]           magx4_reg, magy4_reg, dep4_reg;
    logic                     negx4_reg, negy4_reg;

    // stage 5: focal partial products
    logic                     v5_reg;
    logic [PP_W-1:0]          phx5_reg, plx5_reg, phy5_reg, ply5_reg;
    logic [T_W-1:0]           dep5_reg;
    logic                     negx5_reg, negy5_reg;

    // stage 6: full numerators
    logic                     v6_reg;
    logic [NUM_W-1:0]         nx6_reg, ny6_reg;
    logic [T_W-1:0]           dep6_reg;
    logic                     negx6_reg, negy6_reg;

    // divider stages, index 0 holds the range check
    logic                     dv_v   [QUO_W+1];
    logic [T_W-1:0]           dv_remx [QUO_W+1];
    logic [T_W-1:0]           dv_remy [QUO_W+1];
    logic [QUO_W-1:0]         dv_lowx [QUO_W+1];
    logic [QUO_W-1:0]         dv_lowy [QUO_W+1];
    logic [T_W-1:0]           dv_dep  [QUO_W+1];
    logic                     dv_ovfx [QUO_W+1];
    logic                     dv_ovfy [QUO_W+1];
    logic                     dv_negx [QUO_W+1];
    logic                     dv_negy [QUO_W+1];

    logic [31:0]              out_reg;
    logic                     vout_reg;

    // combinational terms between stages
    logic signed [DOT_W-1:0]  dsum [3];
    logic signed [DOT_W-1:0]  trx, try_, trz;
    logic signed [T_W-1:0]    tx, ty, tz;
    logic [NUM_W-NUM_W+44:0]  nhx, nhy;
    logic                     ovfx, ovfy;
    logic [QUO_W:0]           qx, qy;
    logic signed [26:0]       px8, py8, sqx, sqy;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
            dsum[k] = DOT_W'(p2_reg[3*k]) + DOT_W'(p2_reg[3*k+1]) + DOT_W'(p2_reg[3*k+2]);
        trx  = dot3_reg[1] + DOT_W'(32768);
        try_ = dot3_reg[2] + DOT_W'(32768);
        trz  = dot3_reg[0] + DOT_W'(32768);
        tx   = trx[DOT_W-1:16];
        ty   = try_[DOT_W-1:16];
        tz   = trz[DOT_W-1:16];

        nhx  = nx6_reg[NUM_W-1:QUO_W];
        nhy  = ny6_reg[NUM_W-1:QUO_W];
        ovfx = (nhx >= 45'(dep6_reg));
        ovfy = (nhy >= 45'(dep6_reg));

        // a quotient of 2^24 or more saturates the pixel either way
        qx  = dv_ovfx[QUO_W] ? {1'b1, {QUO_W{1'b0}}} : {1'b0, dv_lowx[QUO_W]};
        qy  = dv_ovfy[QUO_W] ? {1'b1, {QUO_W{1'b0}}} : {1'b0, dv_lowy[QUO_W]};
        sqx = dv_negx[QUO_W] ? -27'(qx) : 27'(qx);
        sqy = dv_negy[QUO_W] ? 27'(qy) : -27'(qy);
        px8 = 27'({screen_reg[15:0], 7'b0}) + sqx;
        py8 = 27'({screen_reg[31:16], 7'b0}) + sqy;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            v5_reg   <= 1'b0;
            v6_reg   <= 1'b0;
            dv_v[0]  <= 1'b0;
            vout_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg   <= s_tvalid && s_tready;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            v4_reg   <= v3_reg;
            v5_reg   <= v4_reg;
            v6_reg   <= v5_reg;
            dv_v[0]  <= v6_reg;
            vout_reg <= dv_v[QUO_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d1_reg[0] <= DIFF_W'(signed'(s_tdata[31:0])) - DIFF_W'(cam_x_reg);
            d1_reg[1] <= DIFF_W'(signed'(s_tdata[63:32])) - DIFF_W'(cam_y_reg);
            d1_reg[2] <= DIFF_W'(signed'(s_tdata[95:64])) - DIFF_W'(cam_z_reg);

            for (int k = 0; k < 3; k++)
                for (int j = 0; j < 3; j++)
                    p2_reg[3*k+j] <= d1_reg[j] * basis_reg[3*k+j];

            for (int k = 0; k < 3; k++)
                dot3_reg[k] <= dsum[k];

            negx4_reg <= tx[T_W-1];
            negy4_reg <= ty[T_W-1];
            magx4_reg <= tx[T_W-1] ? T_W'(-tx) : T_W'(tx);
            magy4_reg <= ty[T_W-1] ? T_W'(-ty) : T_W'(ty);
            // depth below one world unit counts as one
            dep4_reg  <= (tz < T_W'(256)) ? T_W'(256) : T_W'(tz);

            phx5_reg  <= PP_W'(magx4_reg) * PP_W'(focal_reg[31:16]);
            plx5_reg  <= PP_W'(magx4_reg) * PP_W'(focal_reg[15:0]);
            phy5_reg  <= PP_W'(magy4_reg) * PP_W'(focal_reg[31:16]);
            ply5_reg  <= PP_W'(magy4_reg) * PP_W'(focal_reg[15:0]);
            dep5_reg  <= dep4_reg;
            negx5_reg <= negx4_reg;
            negy5_reg <= negy4_reg;

            nx6_reg   <= {phx5_reg, 16'b0} + NUM_W'(plx5_reg);
            ny6_reg   <= {phy5_reg, 16'b0} + NUM_W'(ply5_reg);
            dep6_reg  <= dep5_reg;
            negx6_reg <= negx5_reg;
            negy6_reg <= negy5_reg;

            dv_ovfx[0] <= ovfx;
            dv_ovfy[0] <= ovfy;
            dv_remx[0] <= ovfx ? '0 : nhx[T_W-1:0];
            dv_remy[0] <= ovfy ? '0 : nhy[T_W-1:0];
            dv_lowx[0] <= nx6_reg[QUO_W-1:0];
            dv_lowy[0] <= ny6_reg[QUO_W-1:0];
            dv_dep[0]  <= dep6_reg;
            dv_negx[0] <= negx6_reg;
            dv_negy[0] <= negy6_reg;

            out_reg <= {to_pixel(py8), to_pixel(px8)};
        end
    end

    for (genvar k = 0; k < QUO_W; k++)
    begin : g_div
        logic [T_W:0] shx, shy;
        logic         gex, gey;

        always_comb
        begin
            shx = {dv_remx[k], dv_lowx[k][QUO_W-1]};
            shy = {dv_remy[k], dv_lowy[k][QUO_W-1]};
            gex = (shx >= {1'b0, dv_dep[k]});
            gey = (shy >= {1'b0, dv_dep[k]});
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_v[k+1] <= 1'b0;
            else if (adv)
                dv_v[k+1] <= dv_v[k];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_remx[k+1] <= gex ? T_W'(shx - {1'b0, dv_dep[k]}) : shx[T_W-1:0];
                dv_remy[k+1] <= gey ? T_W'(shy - {1'b0, dv_dep[k]}) : shy[T_W-1:0];
                dv_lowx[k+1] <= {dv_lowx[k][QUO_W-2:0], gex};
                dv_lowy[k+1] <= {dv_lowy[k][QUO_W-2:0], gey};
                dv_dep[k+1]  <= dv_dep[k];
                dv_ovfx[k+1] <= dv_ovfx[k];
                dv_ovfy[k+1] <= dv_ovfy[k];
                dv_negx[k+1] <= dv_negx[k];
                dv_negy[k+1] <= dv_negy[k];
            end
        end
    end

    assign m_tvalid = vout_reg;
    assign m_tdata  = out_reg;

endmodule

@@ tb/w2s_checker.sv @@
module w2s_checker
    import w2s_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [95:0]          s_tdata,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [31:0]          m_tdata,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data,
    output int                   mismatches,
    output int                   pending
);

    int              cam_pos [3];
    int              cam_ang [3];
    int unsigned     fov_reg;
    int unsigned     screen_reg;
    longint          basis [9];
    int unsigned     focal;
    logic [31:0]     pixels_due [$];

    function automatic longint atan_step(input int i);
        return longint'(atan_q30(i[4:0]));
    endfunction

    // angle in 1/128 degree, results in q30
    function automatic void sin_cos(input int a, output longint sn, output longint cs);
        int     u;
        int     q;
        int     r;
        longint x;
        longint y;
        longint z;
        longint xs;
        longint ys;
        u = a % 46080;
        if (u < 0)
            u += 46080;
        q = u / 11520;
        r = u - q * 11520;
        x = 652032874;
        y = 0;
        z = (longint'(r) * 64'sd3373259426 + 11520) / 23040;
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0)
            begin
                x -= ys; y += xs; z -= atan_step(i);
            end
            else
            begin
                x += ys; y -= xs; z += atan_step(i);
            end
        end
        case (q)
            0: begin sn = y;  cs = x;  end
            1: begin sn = x;  cs = -y; end
            2: begin sn = -y; cs = -x; end
            default: begin sn = -x; cs = y; end
        endcase
    endfunction

    function automatic longint rnd16(input longint v);
        return (v + 8192) >>> 14;
    endfunction

    function automatic longint qmul(input longint a, input longint b);
        return (a * b + 32768) >>> 16;
    endfunction

    function automatic longint sat18(input longint v);
        if (v > 131071)
            return 131071;
        if (v < -131072)
            return -131072;
        return v;
    endfunction

    function void rebuild_basis();
        longint s, c, sp, cp, sy, cy, sr, cr, srsp, crsp, num, f;
        int unsigned h;
        longint w;
        h = fov_reg;
        w = longint'(screen_reg[15:0]);
        sin_cos(2 * cam_ang[0], s, c); sp = rnd16(s); cp = rnd16(c);
        sin_cos(2 * cam_ang[1], s, c); sy = rnd16(s); cy = rnd16(c);
        sin_cos(2 * cam_ang[2], s, c); sr = rnd16(s); cr = rnd16(c);
        srsp = qmul(sr, sp);
        crsp = qmul(cr, sp);
        basis[0] = sat18(qmul(cp, cy));
        basis[1] = sat18(qmul(cp, sy));
        basis[2] = sat18(sp);
        basis[3] = sat18(qmul(srsp, cy) - qmul(cr, sy));
        basis[4] = sat18(qmul(srsp, sy) + qmul(cr, cy));
        basis[5] = sat18(-qmul(sr, cp));
        basis[6] = sat18(-(qmul(crsp, cy) + qmul(sr, sy)));
        basis[7] = sat18(qmul(cy, sr) - qmul(crsp, sy));
        basis[8] = sat18(qmul(cr, cp));
        if (h < 64)
            h = 64;
        if (h > 11456)
            h = 11456;
        sin_cos(int'(h), s, c);
        if (s < 1)
            s = 1;
        if (c < 0)
            c = 0;
        num = w * c * 128;
        f = (num + s / 2) / s;
        focal = (f > 64'sh0FFFFFFFF) ? 32'hFFFFFFFF : f[31:0];
    endfunction

    function automatic longint scaled_offset(input longint t, input longint depth,
                                             input int unsigned fs);
        longint unsigned mag, d, fh, fl, a, q1, r1, q;
        mag = (t < 0) ? -t : t;
        d = depth;
        fh = fs >> 16;
        fl = fs & 32'hFFFF;
        a = mag * fh;
        q1 = a / d;
        r1 = a % d;
        q = (q1 << 16) + ((r1 << 16) + mag * fl) / d;
        return (t < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic logic [15:0] round_pixel(input longint p8);
        longint p;
        p = (p8 + 128) >>> 8;
        if (p > 32767)
            p = 32767;
        if (p < -32768)
            p = -32768;
        return p[15:0];
    endfunction

    function logic [31:0] project_point(input logic [95:0] pt);
        longint d [3];
        longint dots [3];
        longint tx, ty, tz, px8, py8;
        for (int k = 0; k < 3; k++)
            d[k] = longint'($signed(pt[32*k +: 32])) - cam_pos[k];
        for (int k = 0; k < 3; k++)
            dots[k] = d[0] * basis[3*k] + d[1] * basis[3*k+1] + d[2] * basis[3*k+2];
        tx = (dots[1] + 32768) >>> 16;
        ty = (dots[2] + 32768) >>> 16;
        tz = (dots[0] + 32768) >>> 16;
        if (tz < 256)
            tz = 256;
        px8 = longint'(screen_reg[15:0]) * 128 + scaled_offset(tx, tz, focal);
        py8 = longint'(screen_reg[31:16]) * 128 - scaled_offset(ty, tz, focal);
        return {round_pixel(py8), round_pixel(px8)};
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic [31:0] want;
        if (!rst_n)
        begin
            cam_pos = '{0, 0, 0};
            cam_ang = '{0, 0, 0};
            fov_reg = 32'(FOV_RESET);
            screen_reg = SCREEN_RESET;
            rebuild_basis();
            pixels_due.delete();
            mismatches = 0;
            pending = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (pixels_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected pixel item %h", m_tdata);
                end
                else
                begin
                    want = pixels_due.pop_front();
                    if (want !== m_tdata)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("pixel mismatch: x exp %0d got %0d, y exp %0d got %0d",
                                     $signed(want[15:0]), $signed(m_tdata[15:0]),
                                     $signed(want[31:16]), $signed(m_tdata[31:16]));
                    end
                end
            end
            if (s_tvalid && s_tready)
                pixels_due.push_back(project_point(s_tdata));
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_CAMERA_X:      cam_pos[0] = $signed(cfg_data);
                    REG_CAMERA_Y:      cam_pos[1] = $signed(cfg_data);
                    REG_CAMERA_Z:      cam_pos[2] = $signed(cfg_data);
                    REG_CAMERA_PITCH:  cam_ang[0] = 32'($signed(cfg_data[15:0]));
                    REG_CAMERA_YAW:    cam_ang[1] = 32'($signed(cfg_data[15:0]));
                    REG_CAMERA_ROLL:   cam_ang[2] = 32'($signed(cfg_data[15:0]));
                    REG_FIELD_OF_VIEW: fov_reg = 32'(cfg_data[13:0]);
                    REG_SCREEN_SIZE:   screen_reg = cfg_data;
                    default: ;
                endcase
                rebuild_basis();
            end
            pending = pixels_due.size();
        end
    end

endmodule

@@ tb/tb_world_to_screen_projection.sv @@
module tb_world_to_screen_projection;
    import w2s_pkg::*;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [95:0]          s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [31:0]          m_tdata;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0]          cfg_data;
    int                   mismatches;
    int                   pending;

    int send_idle_pct;
    int recv_idle_pct;
    int hold_cycles;

    world_to_screen_projection DUT (.*);

    w2s_checker u_checker (.*);

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #3000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // receiver: random stalls, plus a long hold when requested
    initial
    begin
        m_tready = 0;
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                m_tready <= 0;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_point(input logic [31:0] x, input logic [31:0] y,
                              input logic [31:0] z);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 0;
            @(posedge clk);
        end
        s_tvalid <= 1;
        s_tdata <= {z, y, x};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 0;
        repeat (2) @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    function automatic logic [31:0] rand_angle();
        return 32'($signed($urandom_range(46080)) - 23040);
    endfunction

    // points mostly in a box around the camera, some anywhere
    task automatic random_points(input int count, input logic [31:0] cx,
                                 input logic [31:0] cy, input logic [31:0] cz);
        logic [31:0] ofs [3];
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(9) < 7)
            begin
                foreach (ofs[k])
                    ofs[k] = 32'($signed($urandom_range(1 << 20)) - (1 << 19))
                             >>> $urandom_range(12);
                send_point(cx + ofs[0], cy + ofs[1], cz + ofs[2]);
            end
            else
                send_point($urandom, $urandom, $urandom);
        end
    endtask

    initial
    begin
        logic [31:0] cam [3];
        s_tvalid = 0;
        s_tdata = '0;
        cfg_we = 0;
        cfg_index = REG_CAMERA_X;
        cfg_data = '0;
        hold_cycles = 0;
        send_idle_pct = 17;
        recv_idle_pct = 47;
        rst_n = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);

        // reset setup: origin, straight ahead, behind, shallow, extremes, overflow
        send_point(0, 0, 0);
        send_point(32'd256000, 0, 0);
        send_point(32'd256000, 32'd25600, 32'd25600);
        send_point(-32'sd256000, 32'd2560, 0);
        send_point(32'd100, 32'd2560, -32'sd2560);
        send_point(32'h80000000, 32'h80000000, 32'h80000000);
        send_point(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
        send_point(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
        send_point(32'd256, 32'h7FFFFFFF, 32'h80000000);
        send_point(32'd512, 32'hFFFFFFFF, 32'h1);
        drain();

        // angle and fov extremes, zero width, out-of-range fov codes
        write_reg(REG_CAMERA_PITCH, 32'(-16'sd23040));
        write_reg(REG_CAMERA_YAW, 32'd23040);
        write_reg(REG_CAMERA_ROLL, 32'd5760);
        write_reg(REG_FIELD_OF_VIEW, 32'd0);
        send_point(32'd256000, 32'd1000, 32'd2000);
        send_point(32'h12345678, 32'h9ABCDEF0, 32'h0F0F0F0F);
        drain();
        write_reg(REG_FIELD_OF_VIEW, 32'h3FFF);
        write_reg(REG_SCREEN_SIZE, 32'hFFFF0000);
        send_point(32'd256000, 32'd1000, 32'd2000);
        send_point(32'hFFFF0000, 32'd777, 32'h00FF00FF);
        drain();
        write_reg(REG_FIELD_OF_VIEW, 32'd64);
        write_reg(REG_SCREEN_SIZE, 32'hFFFFFFFF);
        send_point(32'd256000, 32'd1000, 32'd2000);
        send_point(32'd256000, 32'd0, 32'd0);
        drain();
        write_reg(REG_FIELD_OF_VIEW, 32'd11456);
        write_reg(REG_CAMERA_PITCH, 32'd23040);
        write_reg(REG_CAMERA_YAW, 32'(-16'sd23040));
        write_reg(REG_CAMERA_ROLL, 32'(-16'sd23040));
        send_point(32'd256000, 32'd1000, 32'd2000);
        send_point(32'h80000000, 32'h7FFFFFFF, 32'h0);
        drain();

        // three random phases, each under a new camera
        for (int phase = 0; phase < 3; phase++)
        begin
            if (phase == 1)
            begin
                send_idle_pct = 47;
                recv_idle_pct = 17;
            end
            else if (phase == 2)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            foreach (cam[k])
                cam[k] = (phase == 2) ? $urandom : $urandom >>> $urandom_range(20, 4);
            write_reg(REG_CAMERA_X, cam[0]);
            write_reg(REG_CAMERA_Y, cam[1]);
            write_reg(REG_CAMERA_Z, cam[2]);
            write_reg(REG_CAMERA_PITCH, rand_angle());
            write_reg(REG_CAMERA_YAW, rand_angle());
            write_reg(REG_CAMERA_ROLL, rand_angle());
            write_reg(REG_FIELD_OF_VIEW, $urandom_range(16383));
            write_reg(REG_SCREEN_SIZE, (phase == 0) ? $urandom : $urandom & 32'h0FFF0FFF);
            random_points(150, cam[0], cam[1], cam[2]);
            if (phase == 2)
                hold_cycles = 200;
            random_points(150, cam[0], cam[1], cam[2]);
            drain();
        end

        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
